[hw/rtl/rop_pkg.sv]
// ----------------------------------------------------------------------------
// rop_pkg
// Shared types, codes and character constants of the inline option run parser.
// ----------------------------------------------------------------------------
package rop_pkg;

    // Highest byte offset reported; the counter is 8 bits wide
    localparam int MAX_RUN_OFFSET = 255;
    localparam int POS_CAP_INT    = (MAX_RUN_OFFSET < 255) ? MAX_RUN_OFFSET : 255;
    localparam logic [7:0] POS_CAP = 8'(POS_CAP_INT);

    // Item kinds
    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_END   = 2'd2,
        KIND_NOP   = 2'd3
    } kind_e_t;

    // Result status codes
    typedef enum logic [3:0] {
        ST_SCAN       = 4'd0,
        ST_BARE       = 4'd1,
        ST_SCOPED     = 4'd2,
        ST_TRUNC      = 4'd3,
        ST_BAD_HYPHEN = 4'd4,
        ST_M_MODULE   = 4'd5,
        ST_J_REFUSED  = 4'd6,
        ST_UNRECOG    = 4'd7,
        ST_IDLE       = 4'd8
    } status_e_t;

    // Flag bit positions in the masks
    localparam int B_I = 0;
    localparam int B_S = 1;
    localparam int B_U = 2;
    localparam int B_N = 3;
    localparam int B_M = 4;
    localparam int B_X = 5;

    // Characters of the option grammar
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_I   = 8'h69;
    localparam logic [7:0] CH_LC_S   = 8'h73;
    localparam logic [7:0] CH_UC_U   = 8'h55;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_M   = 8'h6D;
    localparam logic [7:0] CH_UC_J   = 8'h4A;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_UC_D   = 8'h44;
    localparam logic [7:0] CH_UC_P   = 8'h50;
    localparam logic [7:0] CH_UC_S   = 8'h53;
    localparam logic [7:0] CH_UC_T   = 8'h54;
    localparam logic [7:0] CH_UC_W   = 8'h57;

    // One input item as held in the input register
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_in;
        logic       cur_caseless;
        logic       cur_dotall;
        logic       cur_ungreedy;
        logic       cur_nocap;
        logic       cur_multiline;
        logic [1:0] cur_xlevel;
    } rop_item_t;

    // One result item
    typedef struct packed {
        status_e_t  status;
        logic       new_caseless;
        logic       new_dotall;
        logic       new_ungreedy;
        logic       new_nocap;
        logic       new_multiline;
        logic [1:0] new_xlevel;
        logic [7:0] byte_position;
    } rop_result_t;

    // Parser state carried from byte to byte
    typedef struct packed {
        logic       run_active;
        logic       seen_caret;
        logic       seen_hyphen;
        logic       after_a_letter;
        logic       previous_was_x;
        logic [4:0] set_mask;
        logic [5:0] unset_mask;
        logic [1:0] x_level_touch;
        logic       x_level_touched;
        logic [6:0] enclosing_flags;
        logic [7:0] position_count;
    } rop_state_t;

endpackage

[hw/rtl/rop_ifs.sv]
// ----------------------------------------------------------------------------
// rop_ifs
// Valid/ready channels of the inline option run parser.
// ----------------------------------------------------------------------------
interface rop_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] byte_in;
    logic       cur_caseless;
    logic       cur_dotall;
    logic       cur_ungreedy;
    logic       cur_nocap;
    logic       cur_multiline;
    logic [1:0] cur_xlevel;

    modport source (output valid, kind, byte_in, cur_caseless, cur_dotall, cur_ungreedy,
                    cur_nocap, cur_multiline, cur_xlevel, input ready);
    modport sink   (input valid, kind, byte_in, cur_caseless, cur_dotall, cur_ungreedy,
                    cur_nocap, cur_multiline, cur_xlevel, output ready);
endinterface

interface rop_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic       new_caseless;
    logic       new_dotall;
    logic       new_ungreedy;
    logic       new_nocap;
    logic       new_multiline;
    logic [1:0] new_xlevel;
    logic [7:0] byte_position;

    modport source (output valid, status, new_caseless, new_dotall, new_ungreedy,
                    new_nocap, new_multiline, new_xlevel, byte_position, input ready);
    modport sink   (input valid, status, new_caseless, new_dotall, new_ungreedy,
                    new_nocap, new_multiline, new_xlevel, byte_position, output ready);
endinterface

interface rop_cfg_if;
    logic valid;
    logic ready;
    logic multiline_module_enabled;

    modport source (output valid, multiline_module_enabled, input ready);
    modport sink   (input valid, multiline_module_enabled, output ready);
endinterface

[hw/rtl/rop_in_stage.sv]
// ----------------------------------------------------------------------------
// rop_in_stage
// Input register: captures one transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
module rop_in_stage
    import rop_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rop_item_if.sink    item,
    input  logic        adv,
    output logic        stg_valid,
    output rop_item_t   stg_item
);

    logic      valid_reg;
    logic      valid_next;
    rop_item_t item_reg;
    logic      take;

    // Free slot or the held item leaves this cycle
    assign item.ready = !valid_reg || adv;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (adv)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.kind          <= item.kind;
            item_reg.byte_in       <= item.byte_in;
            item_reg.cur_caseless  <= item.cur_caseless;
            item_reg.cur_dotall    <= item.cur_dotall;
            item_reg.cur_ungreedy  <= item.cur_ungreedy;
            item_reg.cur_nocap     <= item.cur_nocap;
            item_reg.cur_multiline <= item.cur_multiline;
            item_reg.cur_xlevel    <= item.cur_xlevel;
        end
    end

    assign stg_valid = valid_reg;
    assign stg_item  = item_reg;

endmodule

[hw/rtl/rop_core.sv]
// ----------------------------------------------------------------------------
// rop_core
// Parser state, module-enable register and the per-item update logic.
// ----------------------------------------------------------------------------
module rop_core
    import rop_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rop_cfg_if.sink     cfg,
    input  logic        step,
    input  rop_item_t   item_d,
    output rop_result_t res
);

    rop_state_t st_reg;
    rop_state_t st_next;
    logic       mm_en_reg;
    logic       mm_en_next;

    logic [7:0] c;
    logic       first;
    logic       is_sub;
    logic       is_flag;
    logic [4:0] letter_bit;
    status_e_t  bst;
    logic [4:0] f;
    logic [1:0] xl;
    kind_e_t    kind;

    // Configuration register, always ready
    assign cfg.ready = 1'b1;

    always_comb
    begin
        mm_en_next = mm_en_reg;
        if (cfg.valid)
        begin
            mm_en_next = cfg.multiline_module_enabled;
        end
    end

    // Letter decode
    always_comb
    begin
        c       = item_d.byte_in;
        is_sub  = (c == CH_UC_D) || (c == CH_UC_P) || (c == CH_UC_S) ||
                  (c == CH_UC_T) || (c == CH_UC_W);
        is_flag = 1'b1;
        letter_bit = '0;
        priority if (c == CH_LC_I)
        begin
            letter_bit[B_I] = 1'b1;
        end
        else if (c == CH_LC_S)
        begin
            letter_bit[B_S] = 1'b1;
        end
        else if (c == CH_UC_U)
        begin
            letter_bit[B_U] = 1'b1;
        end
        else if (c == CH_LC_N)
        begin
            letter_bit[B_N] = 1'b1;
        end
        else if (c == CH_LC_M)
        begin
            letter_bit[B_M] = 1'b1;
        end
        else
        begin
            is_flag = 1'b0;
        end
    end

    // Flags on a terminator: caret clears all but U, sets apply, unsets win
    always_comb
    begin
        f  = st_reg.enclosing_flags[4:0];
        xl = (st_reg.enclosing_flags[6:5] == 2'd3) ? 2'd2 : st_reg.enclosing_flags[6:5];
        if (st_reg.seen_caret)
        begin
            f  = f & (5'd1 << B_U);
            xl = 2'd0;
        end
        f = f | st_reg.set_mask;
        if (st_reg.x_level_touched)
        begin
            xl = st_reg.x_level_touch;
        end
        f = f & ~st_reg.unset_mask[4:0];
        if (st_reg.unset_mask[B_X])
        begin
            xl = 2'd0;
        end
    end

    // Byte grammar
    always_comb
    begin
        st_next = st_reg;
        first   = (st_reg.position_count == 8'd0);
        bst     = ST_SCAN;
        kind    = kind_e_t'(item_d.kind);

        res               = '0;
        res.status        = ST_IDLE;

        priority if (kind == KIND_START)
        begin
            st_next                 = '0;
            st_next.run_active      = 1'b1;
            st_next.enclosing_flags = {item_d.cur_xlevel, item_d.cur_multiline,
                                       item_d.cur_nocap, item_d.cur_ungreedy,
                                       item_d.cur_dotall, item_d.cur_caseless};
            res.status              = ST_SCAN;
        end
        else if (!st_reg.run_active)
        begin
            res.status = ST_IDLE;
        end
        else if (kind == KIND_NOP)
        begin
            res.status = ST_SCAN;
        end
        else if (kind == KIND_END)
        begin
            res.byte_position  = st_reg.position_count;
            res.status         = ST_TRUNC;
            st_next.run_active = 1'b0;
        end
        else
        begin
            res.byte_position      = st_reg.position_count;
            st_next.previous_was_x = (c == CH_LC_X);
            st_next.after_a_letter = 1'b0;

            priority if (st_reg.after_a_letter && is_sub)
            begin
                bst = ST_SCAN;
            end
            else if (c == CH_RPAREN)
            begin
                bst = ST_BARE;
            end
            else if (c == CH_COLON)
            begin
                bst = ST_SCOPED;
            end
            else if (c == CH_CARET)
            begin
                if (!first)
                begin
                    bst = ST_UNRECOG;
                end
                else
                begin
                    st_next.seen_caret = 1'b1;
                end
            end
            else if (c == CH_HYPHEN)
            begin
                if (st_reg.seen_caret || st_reg.seen_hyphen)
                begin
                    bst = ST_BAD_HYPHEN;
                end
                else
                begin
                    st_next.seen_hyphen = 1'b1;
                end
            end
            else if (is_flag)
            begin
                if (letter_bit[B_M] && !st_reg.seen_hyphen && !mm_en_reg)
                begin
                    bst = ST_M_MODULE;
                end
                else if (st_reg.seen_hyphen)
                begin
                    st_next.unset_mask = st_reg.unset_mask | {1'b0, letter_bit};
                end
                else
                begin
                    st_next.set_mask = st_reg.set_mask | letter_bit;
                end
            end
            else if (c == CH_LC_X)
            begin
                if (st_reg.seen_hyphen)
                begin
                    st_next.unset_mask[B_X] = 1'b1;
                end
                else
                begin
                    st_next.x_level_touch   = st_reg.previous_was_x ? 2'd2 : 2'd1;
                    st_next.x_level_touched = 1'b1;
                end
            end
            else if (c == CH_UC_J)
            begin
                if (!st_reg.seen_hyphen)
                begin
                    bst = ST_J_REFUSED;
                end
            end
            else if (c == CH_LC_R)
            begin
                bst = ST_SCAN;
            end
            else if (c == CH_LC_A)
            begin
                st_next.after_a_letter = 1'b1;
            end
            else
            begin
                bst = ST_UNRECOG;
            end

            // Offset counter saturates at the cap
            if (st_reg.position_count < POS_CAP)
            begin
                st_next.position_count = st_reg.position_count + 8'd1;
            end

            res.status = bst;
            if (bst != ST_SCAN)
            begin
                st_next.run_active = 1'b0;
            end
            if ((bst == ST_BARE) || (bst == ST_SCOPED))
            begin
                res.new_caseless  = f[B_I];
                res.new_dotall    = f[B_S];
                res.new_ungreedy  = f[B_U];
                res.new_nocap     = f[B_N];
                res.new_multiline = f[B_M];
                res.new_xlevel    = xl;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= '0;
            mm_en_reg <= 1'b1;
        end
        else
        begin
            mm_en_reg <= mm_en_next;
            if (step)
            begin
                st_reg <= st_next;
            end
        end
    end

endmodule

[hw/rtl/rop_out_stage.sv]
// ----------------------------------------------------------------------------
// rop_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module rop_out_stage
    import rop_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  rop_result_t res_d,
    output logic        room,
    rop_result_if.source result
);

    logic        valid_reg;
    logic        valid_next;
    rop_result_t res_reg;

    // Slot free now or drained this cycle
    assign room = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_d;
        end
    end

    assign result.valid         = valid_reg;
    assign result.status        = res_reg.status;
    assign result.new_caseless  = res_reg.new_caseless;
    assign result.new_dotall    = res_reg.new_dotall;
    assign result.new_ungreedy  = res_reg.new_ungreedy;
    assign result.new_nocap     = res_reg.new_nocap;
    assign result.new_multiline = res_reg.new_multiline;
    assign result.new_xlevel    = res_reg.new_xlevel;
    assign result.byte_position = res_reg.byte_position;

endmodule

[hw/rtl/regex_inline_option_run_parser_top.sv]
// ----------------------------------------------------------------------------
// regex_inline_option_run_parser_top
// Inline option run parser: checks the option letters of a "(?" group byte by
// byte and reports the resulting modifier flags or the first error.
// ----------------------------------------------------------------------------
// The parser takes one transaction per clock while the result side is not
// stalled and returns exactly one result transaction for each. An accepted
// item passes from the input register to the result register; the grammar
// and flag logic update the parser state and load the result register at the
// same edge, so a sustained rate of one item per cycle holds. item.ready
// follows result.ready combinationally: it drops only while both the input
// and result registers hold work and the result is not taken. The one
// configuration register is written at any cycle and should change only
// while no run is in flight.
module regex_inline_option_run_parser_top
    import rop_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rop_item_if.sink      item,
    rop_result_if.source  result,
    rop_cfg_if.sink       cfg
);

    logic        stg_valid;
    rop_item_t   stg_item;
    logic        room;
    logic        adv;
    rop_result_t core_res;

    // Item moves into the result register when there is room
    assign adv = stg_valid && room;

    rop_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .adv       (adv),
        .stg_valid (stg_valid),
        .stg_item  (stg_item)
    );

    rop_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (adv),
        .item_d (stg_item),
        .res    (core_res)
    );

    rop_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (adv),
        .res_d  (core_res),
        .room   (room),
        .result (result)
    );

endmodule

[hw/rtl/rop_checker.sv]
// ----------------------------------------------------------------------------
// rop_checker
// Port-level assertions for the inline option run parser, bound to the top.
// ----------------------------------------------------------------------------
module rop_checker
    import rop_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [3:0] res_status,
    input logic       res_caseless,
    input logic       res_dotall,
    input logic       res_ungreedy,
    input logic       res_nocap,
    input logic       res_multiline,
    input logic [1:0] res_xlevel,
    input logic [7:0] res_position
);

    logic res_done;
    logic res_flags_any;

    assign res_done      = (res_status == ST_BARE) || (res_status == ST_SCOPED);
    assign res_flags_any = res_caseless || res_dotall || res_ungreedy || res_nocap ||
                           res_multiline || (res_xlevel != 2'd0);

    // Stalled result transaction holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status) &&
        $stable(res_position) && $stable(res_xlevel))
        else $error("result changed while stalled");

    // Empty result register never back-pressures the input
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // Flags only on a terminator
    a_flags_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_done |-> !res_flags_any)
        else $error("flags reported without a terminator");

    // Extended level never 3
    a_xlevel: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_xlevel != 2'd3)
        else $error("extended level out of range");

    // Idle result carries no offset
    a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == ST_IDLE) |-> res_position == 8'd0)
        else $error("idle result with nonzero offset");

endmodule

bind regex_inline_option_run_parser_top rop_checker u_rop_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (item.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_status    (result.status),
    .res_caseless  (result.new_caseless),
    .res_dotall    (result.new_dotall),
    .res_ungreedy  (result.new_ungreedy),
    .res_nocap     (result.new_nocap),
    .res_multiline (result.new_multiline),
    .res_xlevel    (result.new_xlevel),
    .res_position  (result.byte_position)
);
